// File: hdl/packet_header_filter_unit_macros.svh
// Assertion macros shared by the packet header filter modules.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef PACKET_HEADER_FILTER_UNIT_MACROS_SVH
`define PACKET_HEADER_FILTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PHF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PHF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/phf_pkg.sv
// Package for the packet header filter: payload structs, configuration
// struct, register indexes, parse phases and protocol constants. No dependencies.
`timescale 1ns / 1ps

package phf_pkg;

	localparam int MAX_EXT_HEADERS = 8;
	localparam int EXT_CNT_W       = $clog2(MAX_EXT_HEADERS + 1);
	localparam int OFFSET_W        = 12;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;

	localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
	localparam logic [7:0] NH_ROUTING    = 8'd43;
	localparam logic [7:0] NH_FRAGMENT   = 8'd44;
	localparam logic [7:0] PROTO_TCP     = 8'd6;
	localparam logic [7:0] PROTO_UDP     = 8'd17;

	localparam logic [OFFSET_W-1:0] V4_MIN_LEN     = 12'd20;
	localparam logic [OFFSET_W-1:0] V4_PROTO_OFS   = 12'd9;
	localparam logic [OFFSET_W-1:0] V4_ADDR_FIRST  = 12'd12;
	localparam logic [OFFSET_W-1:0] V4_ADDR_LAST   = 12'd19;
	localparam logic [OFFSET_W-1:0] V6_NH_OFS      = 12'd6;
	localparam logic [OFFSET_W-1:0] V6_ADDR_FIRST  = 12'd8;
	localparam logic [OFFSET_W-1:0] V6_SRC_HI_LAST = 12'd15;
	localparam logic [OFFSET_W-1:0] V6_SRC_LO_LAST = 12'd23;
	localparam logic [OFFSET_W-1:0] V6_DST_HI_LAST = 12'd31;
	localparam logic [OFFSET_W-1:0] V6_DST_LO_LAST = 12'd39;
	localparam logic [OFFSET_W-1:0] EXT_LEN_OFS    = 12'd1;
	localparam logic [OFFSET_W-1:0] L4_PORTS_LAST  = 12'd3;

	// Wildcard mask bit positions.
	localparam int WC_L3     = 0;
	localparam int WC_L4     = 1;
	localparam int WC_V4_SRC = 2;
	localparam int WC_V4_DST = 3;
	localparam int WC_V6_SRC = 4;
	localparam int WC_V6_DST = 5;
	localparam int WC_SPORT  = 6;
	localparam int WC_DPORT  = 7;

	typedef enum logic [2:0] {
		REG_WILDCARD_MASK,
		REG_IPV4_ADDRESS_PAIR,
		REG_PROTOCOL_PAIR,
		REG_PORT_PAIR,
		REG_IPV6_SOURCE_UPPER,
		REG_IPV6_SOURCE_LOWER,
		REG_IPV6_DEST_UPPER,
		REG_IPV6_DEST_LOWER
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_V4,
		PH_V6,
		PH_EXT,
		PH_L4,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] ethertype;
		logic        first_byte;
		logic        last_byte;
	} byte_item_t;

	typedef struct packed {
		logic        matched;
		logic [15:0] net_protocol;
		logic [7:0]  transport_protocol;
		logic [31:0] ipv4_source;
		logic [31:0] ipv4_dest;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} result_item_t;

	typedef struct packed {
		logic [7:0]  wildcard_mask;
		logic [63:0] ipv4_address_pair;
		logic [23:0] protocol_pair;
		logic [31:0] port_pair;
		logic [63:0] ipv6_source_upper;
		logic [63:0] ipv6_source_lower;
		logic [63:0] ipv6_dest_upper;
		logic [63:0] ipv6_dest_lower;
	} filter_cfg_t;

endpackage

// File: hdl/phf_parser.sv
// Header parser and field comparator: holds the per-packet parse state and
// handles one byte per take. Depends on phf_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "packet_header_filter_unit_macros.svh"

module phf_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  phf_pkg::byte_item_t   item,
	input  logic                  take,
	input  phf_pkg::filter_cfg_t  cfg,
	output logic                  emit,
	output phf_pkg::result_item_t result
);
	import phf_pkg::*;

	phase_t                phase_q, phase_d, ph_p;
	logic [OFFSET_W-1:0]   offset_q, offset_d;
	logic [OFFSET_W-1:0]   hlen_q, hlen_d;
	logic [7:0]            nh_q, nh_d;
	logic [EXT_CNT_W-1:0]  ext_cnt_q, ext_cnt_d;
	logic                  ok_q, ok_d;
	logic [15:0]           etype_q, etype_d;
	logic [63:0]           addr_q, addr_d;
	logic [31:0]           port_q, port_d;
	logic                  seen_q, seen_d;

	// Next-state logic: apply the start-of-packet reset, then the byte itself.
	always_comb begin
		logic [7:0]          b;
		logic [OFFSET_W-1:0] o;
		logic [OFFSET_W-1:0] v4_len;
		logic                v6_next;
		logic                l3_end;
		b       = item.data_byte;
		v6_next = 1'b0;
		l3_end  = 1'b0;
		v4_len  = '0;

		ph_p      = phase_q;
		offset_d  = offset_q;
		hlen_d    = hlen_q;
		nh_d      = nh_q;
		ext_cnt_d = ext_cnt_q;
		ok_d      = ok_q;
		etype_d   = etype_q;
		addr_d    = addr_q;
		port_d    = port_q;
		seen_d    = seen_q;

		if (item.first_byte) begin
			etype_d   = item.ethertype;
			offset_d  = '0;
			hlen_d    = '0;
			nh_d      = '0;
			ext_cnt_d = '0;
			addr_d    = '0;
			port_d    = '0;
			seen_d    = 1'b0;
			ok_d      = cfg.wildcard_mask[WC_L3] ||
				(item.ethertype == cfg.protocol_pair[23:8]);
			if (item.ethertype == ETH_IPV4) begin
				ph_p = PH_V4;
			end else if (item.ethertype == ETH_IPV6) begin
				ph_p = PH_V6;
			end else begin
				ok_d = 1'b0;
				ph_p = PH_DONE;
			end
		end

		o = offset_d;
		case (ph_p)
			PH_V4: begin
				if (o == '0) begin
					v4_len = {6'd0, b[3:0], 2'b00};
					hlen_d = (v4_len < V4_MIN_LEN) ? V4_MIN_LEN : v4_len;
				end
				if (o == V4_PROTO_OFS) nh_d = b;
				if (o >= V4_ADDR_FIRST && o <= V4_ADDR_LAST) addr_d = {addr_d[55:0], b};
				if (o == V4_ADDR_LAST) begin
					if (!cfg.wildcard_mask[WC_V4_SRC] &&
						addr_d[63:32] != cfg.ipv4_address_pair[63:32]) ok_d = 1'b0;
					if (!cfg.wildcard_mask[WC_V4_DST] &&
						addr_d[31:0] != cfg.ipv4_address_pair[31:0]) ok_d = 1'b0;
				end
				offset_d = o + 1'b1;
				if (offset_d >= V4_MIN_LEN && offset_d >= hlen_d) l3_end = 1'b1;
			end
			PH_V6: begin
				if (o == V6_NH_OFS) nh_d = b;
				if (o >= V6_ADDR_FIRST && o <= V6_DST_LO_LAST) addr_d = {addr_d[55:0], b};
				if (o == V6_SRC_HI_LAST && !cfg.wildcard_mask[WC_V6_SRC] &&
					addr_d != cfg.ipv6_source_upper) ok_d = 1'b0;
				if (o == V6_SRC_LO_LAST && !cfg.wildcard_mask[WC_V6_SRC] &&
					addr_d != cfg.ipv6_source_lower) ok_d = 1'b0;
				if (o == V6_DST_HI_LAST && !cfg.wildcard_mask[WC_V6_DST] &&
					addr_d != cfg.ipv6_dest_upper) ok_d = 1'b0;
				if (o == V6_DST_LO_LAST && !cfg.wildcard_mask[WC_V6_DST] &&
					addr_d != cfg.ipv6_dest_lower) ok_d = 1'b0;
				offset_d = o + 1'b1;
				if (o == V6_DST_LO_LAST) v6_next = 1'b1;
			end
			PH_EXT: begin
				if (o == '0) nh_d = b;
				// Extension header length counts 8-octet units beyond the first.
				if (o == EXT_LEN_OFS) hlen_d = {({1'b0, b} + 9'd1), 3'b000};
				offset_d = o + 1'b1;
				if (o >= EXT_LEN_OFS && offset_d >= hlen_d) v6_next = 1'b1;
			end
			PH_L4: begin
				port_d   = {port_d[23:0], b};
				offset_d = o + 1'b1;
				if (o >= L4_PORTS_LAST) begin
					seen_d = 1'b1;
					if (!cfg.wildcard_mask[WC_SPORT] &&
						port_d[31:16] != cfg.port_pair[31:16]) ok_d = 1'b0;
					if (!cfg.wildcard_mask[WC_DPORT] &&
						port_d[15:0] != cfg.port_pair[15:0]) ok_d = 1'b0;
					ph_p = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		if (v6_next) begin
			if ((nh_d == NH_HOP_BY_HOP || nh_d == NH_ROUTING || nh_d == NH_FRAGMENT) &&
				ext_cnt_d < EXT_CNT_W'(MAX_EXT_HEADERS)) begin
				ext_cnt_d = ext_cnt_d + 1'b1;
				ph_p      = PH_EXT;
				offset_d  = '0;
				hlen_d    = '0;
			end else begin
				l3_end = 1'b1;
			end
		end

		if (l3_end) begin
			if (!cfg.wildcard_mask[WC_L4] && nh_d != cfg.protocol_pair[7:0]) ok_d = 1'b0;
			offset_d = '0;
			ph_p     = (nh_d == PROTO_TCP || nh_d == PROTO_UDP) ? PH_L4 : PH_DONE;
		end

		phase_d = (item.last_byte && ph_p != PH_IDLE) ? PH_IDLE : ph_p;
	end

	// Output logic: the verdict and fields as they stand after this byte.
	always_comb begin
		logic v4_done;
		v4_done = (etype_d == ETH_IPV4) && (ph_p != PH_V4 || offset_d >= V4_MIN_LEN);
		emit                = item_valid && item.last_byte &&
			(item.first_byte || phase_q != PH_IDLE);
		result.matched            = ok_d && (ph_p == PH_DONE);
		result.net_protocol       = etype_d;
		result.transport_protocol = nh_d;
		result.ipv4_source        = v4_done ? addr_d[63:32] : 32'd0;
		result.ipv4_dest          = v4_done ? addr_d[31:0] : 32'd0;
		result.source_port        = seen_d ? port_d[31:16] : 16'd0;
		result.dest_port          = seen_d ? port_d[15:0] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			offset_q  <= '0;
			hlen_q    <= '0;
			nh_q      <= '0;
			ext_cnt_q <= '0;
			ok_q      <= 1'b1;
			etype_q   <= '0;
			addr_q    <= '0;
			port_q    <= '0;
			seen_q    <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_d;
			offset_q  <= offset_d;
			hlen_q    <= hlen_d;
			nh_q      <= nh_d;
			ext_cnt_q <= ext_cnt_d;
			ok_q      <= ok_d;
			etype_q   <= etype_d;
			addr_q    <= addr_d;
			port_q    <= port_d;
			seen_q    <= seen_d;
		end
	end

	`PHF_ASSERT_NEXT(a_idle_after_result, take && emit, phase_q == PH_IDLE, "parser not idle after result")
	`PHF_ASSERT_NOW(a_ext_limit, 1'b1, ext_cnt_q <= EXT_CNT_W'(MAX_EXT_HEADERS), "extension count over limit")
	`PHF_ASSERT_NOW(a_ports_need_l4, seen_q, nh_q == PROTO_TCP || nh_q == PROTO_UDP, "ports read for non TCP/UDP")

endmodule

// File: hdl/packet_header_filter_unit.sv
// Top level of the packet header filter: configuration registers, input
// register, result register. Depends on phf_pkg, phf_parser and the macros.
`timescale 1ns / 1ps
`include "packet_header_filter_unit_macros.svh"

// Channel  | Signals                                    | Moves
// ---------+--------------------------------------------+-------------------------
// byte     | byte_valid, byte_stall, byte_item          | one packet byte + flags
// result   | result_valid, result_stall, result_item    | verdict and fields
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data  | one register write
//
// A byte is taken every cycle while byte_stall is low; its result moves
// through the input register, then the parse logic into the result register.
// Reset clears the parse state and loads the register reset values.
// A stalled result blocks only a byte that would make a new result; one byte
// waits in the input register meanwhile. cfg_ready is always high.

module packet_header_filter_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  phf_pkg::byte_item_t   byte_item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output phf_pkg::result_item_t result_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  phf_pkg::reg_index_t   cfg_index,
	input  logic [63:0]           cfg_data
);
	import phf_pkg::*;

	filter_cfg_t  cfg_q;
	logic         valid_s1;
	byte_item_t   item_s1;
	logic         emit;
	logic         advance;
	result_item_t parsed;
	logic         result_valid_q;
	result_item_t result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wildcard_mask     <= 8'hFF;
			cfg_q.ipv4_address_pair <= '0;
			cfg_q.protocol_pair     <= '0;
			cfg_q.port_pair         <= '0;
			cfg_q.ipv6_source_upper <= '0;
			cfg_q.ipv6_source_lower <= '0;
			cfg_q.ipv6_dest_upper   <= '0;
			cfg_q.ipv6_dest_lower   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WILDCARD_MASK:     cfg_q.wildcard_mask     <= cfg_data[7:0];
				REG_IPV4_ADDRESS_PAIR: cfg_q.ipv4_address_pair <= cfg_data;
				REG_PROTOCOL_PAIR:     cfg_q.protocol_pair     <= cfg_data[23:0];
				REG_PORT_PAIR:         cfg_q.port_pair         <= cfg_data[31:0];
				REG_IPV6_SOURCE_UPPER: cfg_q.ipv6_source_upper <= cfg_data;
				REG_IPV6_SOURCE_LOWER: cfg_q.ipv6_source_lower <= cfg_data;
				REG_IPV6_DEST_UPPER:   cfg_q.ipv6_dest_upper   <= cfg_data;
				REG_IPV6_DEST_LOWER:   cfg_q.ipv6_dest_lower   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The held byte moves on unless it would produce a result while the
	// result register is full and stalled.
	assign advance    = valid_s1 && (!emit || !result_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	phf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.take       (advance),
		.cfg        (cfg_q),
		.emit       (emit),
		.result     (parsed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= parsed;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	`PHF_ASSERT_NOW(a_stall_cause, byte_stall, result_valid && result_stall, "input stalled without a stalled result")
	`PHF_ASSERT_NEXT(a_result_loaded, advance && emit, result_valid, "result transaction lost")
	`PHF_ASSERT_NOW(a_no_overwrite, advance && emit && result_valid, !result_stall, "result overwritten while stalled")

endmodule

// File: sim/tb.sv
// Self-checking testbench for packet_header_filter_unit: random and directed IPv4,
// IPv6 and non-IP packets, checked against a behavioral filter model kept here.
// Depends only on phf_pkg and the RTL under hdl.
`timescale 1ns / 1ps

module tb;
	import phf_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_HOLD      = 200;

	typedef enum {PKT_V4, PKT_V6, PKT_OTHER} pkt_kind_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         byte_valid = 1'b0;
	logic         byte_stall;
	byte_item_t   byte_item = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_item;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	reg_index_t   cfg_index = REG_WILDCARD_MASK;
	logic [63:0]  cfg_data = '0;

	packet_header_filter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register values as the block should hold them.
	filter_cfg_t filter_setting;

	// Parser state of the behavioral filter.
	phase_t                p_phase = PH_IDLE;
	logic [11:0]           p_ofs = '0;
	logic [11:0]           p_len = '0;
	logic [7:0]            p_next = '0;
	logic [EXT_CNT_W-1:0]  p_ext = '0;
	logic                  p_ok = 1'b1;
	logic [15:0]           p_ethertype = '0;
	logic [63:0]           p_addr = '0;
	logic [31:0]           p_ports = '0;
	logic                  p_ports_seen = 1'b0;

	byte_item_t   pending_bytes[$];
	result_item_t expected_verdicts[$];

	bit calm = 1'b0;
	bit aim_exact = 1'b0;
	int error_count = 0;
	int bytes_taken = 0;
	int verdicts_seen = 0;
	int matches_seen = 0;
	int stim_bytes = 0;
	int stim_packets = 0;
	int cfg_writes = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	task automatic report_error(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_error($sformatf("%s: got %0h, want %0h", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Behavioral filter
	// ------------------------------------------------------------------
	function automatic void end_of_l3();
		if (!filter_setting.wildcard_mask[WC_L4] && p_next != filter_setting.protocol_pair[7:0])
			p_ok = 1'b0;
		p_ofs = '0;
		p_phase = (p_next == PROTO_TCP || p_next == PROTO_UDP) ? PH_L4 : PH_DONE;
	endfunction

	// Either step into one more extension header or finish the L3 header.
	function automatic void after_v6_header();
		if ((p_next == NH_HOP_BY_HOP || p_next == NH_ROUTING || p_next == NH_FRAGMENT)
				&& p_ext < MAX_EXT_HEADERS) begin
			p_ext = p_ext + 1'b1;
			p_phase = PH_EXT;
			p_ofs = '0;
			p_len = '0;
		end else begin
			end_of_l3();
		end
	endfunction

	task automatic predict_verdict(input byte_item_t it);
		logic [11:0]  o;
		logic [11:0]  ihl_len;
		logic [7:0]   b;
		logic         v4_done;
		result_item_t r;
		b = it.data_byte;
		if (it.first_byte) begin
			p_ethertype = it.ethertype;
			p_ofs = '0;
			p_len = '0;
			p_next = '0;
			p_ext = '0;
			p_ok = 1'b1;
			p_addr = '0;
			p_ports = '0;
			p_ports_seen = 1'b0;
			if (!filter_setting.wildcard_mask[WC_L3]
					&& it.ethertype != filter_setting.protocol_pair[23:8])
				p_ok = 1'b0;
			if (it.ethertype == ETH_IPV4) begin
				p_phase = PH_V4;
			end else if (it.ethertype == ETH_IPV6) begin
				p_phase = PH_V6;
			end else begin
				p_ok = 1'b0;
				p_phase = PH_DONE;
			end
		end
		if (p_phase != PH_IDLE) begin
			o = p_ofs;
			case (p_phase)
			PH_V4: begin
				if (o == 0) begin
					ihl_len = {6'd0, b[3:0], 2'b00};
					p_len = (ihl_len < 20) ? 12'd20 : ihl_len;
				end
				if (o == 9)
					p_next = b;
				if (o >= 12 && o <= 19)
					p_addr = {p_addr[55:0], b};
				if (o == 19) begin
					if (!filter_setting.wildcard_mask[WC_V4_SRC]
							&& p_addr[63:32] != filter_setting.ipv4_address_pair[63:32])
						p_ok = 1'b0;
					if (!filter_setting.wildcard_mask[WC_V4_DST]
							&& p_addr[31:0] != filter_setting.ipv4_address_pair[31:0])
						p_ok = 1'b0;
				end
				p_ofs = o + 1'b1;
				if (p_ofs >= 20 && p_ofs >= p_len)
					end_of_l3();
			end
			PH_V6: begin
				if (o == 6)
					p_next = b;
				if (o >= 8 && o <= 39)
					p_addr = {p_addr[55:0], b};
				if (o == 15 && !filter_setting.wildcard_mask[WC_V6_SRC]
						&& p_addr != filter_setting.ipv6_source_upper)
					p_ok = 1'b0;
				if (o == 23 && !filter_setting.wildcard_mask[WC_V6_SRC]
						&& p_addr != filter_setting.ipv6_source_lower)
					p_ok = 1'b0;
				if (o == 31 && !filter_setting.wildcard_mask[WC_V6_DST]
						&& p_addr != filter_setting.ipv6_dest_upper)
					p_ok = 1'b0;
				if (o == 39 && !filter_setting.wildcard_mask[WC_V6_DST]
						&& p_addr != filter_setting.ipv6_dest_lower)
					p_ok = 1'b0;
				p_ofs = o + 1'b1;
				if (o == 39)
					after_v6_header();
			end
			PH_EXT: begin
				if (o == 0)
					p_next = b;
				if (o == 1)
					p_len = (12'(b) + 12'd1) * 12'd8;
				p_ofs = o + 1'b1;
				if (o >= 1 && p_ofs >= p_len)
					after_v6_header();
			end
			PH_L4: begin
				p_ports = {p_ports[23:0], b};
				p_ofs = o + 1'b1;
				if (o >= 3) begin
					p_ports_seen = 1'b1;
					if (!filter_setting.wildcard_mask[WC_SPORT]
							&& p_ports[31:16] != filter_setting.port_pair[31:16])
						p_ok = 1'b0;
					if (!filter_setting.wildcard_mask[WC_DPORT]
							&& p_ports[15:0] != filter_setting.port_pair[15:0])
						p_ok = 1'b0;
					p_phase = PH_DONE;
				end
			end
			default: begin
			end
			endcase
			if (it.last_byte) begin
				v4_done = p_ethertype == ETH_IPV4 && (p_phase != PH_V4 || p_ofs >= 20);
				r.matched = p_ok && p_phase == PH_DONE;
				r.net_protocol = p_ethertype;
				r.transport_protocol = p_next;
				r.ipv4_source = v4_done ? p_addr[63:32] : 32'd0;
				r.ipv4_dest = v4_done ? p_addr[31:0] : 32'd0;
				r.source_port = p_ports_seen ? p_ports[31:16] : 16'd0;
				r.dest_port = p_ports_seen ? p_ports[15:0] : 16'd0;
				expected_verdicts.push_back(r);
				p_phase = PH_IDLE;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Packet generation
	// ------------------------------------------------------------------
	// Mostly the configured value, so that full matches are common.
	function automatic logic [63:0] near(input logic [63:0] want);
		return (aim_exact || $urandom_range(0, 3) != 0) ? want : {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(0, 3))
		0: return PROTO_TCP;
		1: return PROTO_UDP;
		2: return filter_setting.protocol_pair[7:0];
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_ext_code();
		case ($urandom_range(0, 2))
		0: return NH_HOP_BY_HOP;
		1: return NH_ROUTING;
		default: return NH_FRAGMENT;
		endcase
	endfunction

	// opt is the IHL for IPv4, the number of extension headers for IPv6 and the
	// ethertype otherwise. keep > 0 cuts the packet short; closed marks the last byte.
	task automatic gen_packet(input pkt_kind_t kind, input int opt, input logic [7:0] proto,
			input int keep, input bit closed);
		logic [7:0]  pkt[$];
		logic [7:0]  chain[$];
		logic [15:0] et;
		logic [63:0] a;
		logic [63:0] c;
		logic [31:0] pp;
		int          len;
		byte_item_t  it;
		case (kind)
		PKT_V4: begin
			et = ETH_IPV4;
			len = (opt < 5) ? 20 : opt * 4;
			for (int i = 0; i < len; i++)
				pkt.push_back(8'($urandom));
			pkt[0] = {4'($urandom), 4'(opt)};
			pkt[9] = proto;
			a = near(filter_setting.ipv4_address_pair);
			for (int i = 0; i < 8; i++)
				pkt[12 + i] = a[63 - 8 * i -: 8];
		end
		PKT_V6: begin
			et = ETH_IPV6;
			for (int i = 0; i < 40; i++)
				pkt.push_back(8'($urandom));
			for (int i = 0; i < opt; i++)
				chain.push_back(pick_ext_code());
			chain.push_back(proto);
			pkt[6] = chain[0];
			a = near(filter_setting.ipv6_source_upper);
			c = near(filter_setting.ipv6_source_lower);
			for (int i = 0; i < 8; i++) begin
				pkt[8 + i] = a[63 - 8 * i -: 8];
				pkt[16 + i] = c[63 - 8 * i -: 8];
			end
			a = near(filter_setting.ipv6_dest_upper);
			c = near(filter_setting.ipv6_dest_lower);
			for (int i = 0; i < 8; i++) begin
				pkt[24 + i] = a[63 - 8 * i -: 8];
				pkt[32 + i] = c[63 - 8 * i -: 8];
			end
			for (int i = 0; i < opt; i++) begin
				len = $urandom_range(0, 1);
				pkt.push_back(chain[i + 1]);
				pkt.push_back(8'(len));
				for (int j = 0; j < (len + 1) * 8 - 2; j++)
					pkt.push_back(8'($urandom));
			end
		end
		default: begin
			et = 16'(opt);
			for (int i = $urandom_range(1, 4); i > 0; i--)
				pkt.push_back(8'($urandom));
		end
		endcase
		if (kind != PKT_OTHER && (proto == PROTO_TCP || proto == PROTO_UDP)) begin
			pp = 32'(near({32'd0, filter_setting.port_pair}));
			for (int i = 0; i < 4; i++)
				pkt.push_back(pp[31 - 8 * i -: 8]);
		end
		if (kind != PKT_OTHER)
			for (int i = $urandom_range(0, 6); i > 0; i--)
				pkt.push_back(8'($urandom));
		if (keep > 0)
			while (pkt.size() > keep)
				void'(pkt.pop_back());
		foreach (pkt[i]) begin
			it.data_byte = pkt[i];
			it.ethertype = (i == 0) ? et : 16'($urandom);
			it.first_byte = (i == 0);
			it.last_byte = closed && (i == pkt.size() - 1);
			pending_bytes.push_back(it);
			stim_bytes++;
		end
		if (closed)
			stim_packets++;
	endtask

	// Bytes outside any packet; the parser must be idle when they arrive.
	task automatic add_stray_bytes(input int n);
		byte_item_t it;
		repeat (n) begin
			it.data_byte = 8'($urandom);
			it.ethertype = 16'($urandom);
			it.first_byte = 1'b0;
			it.last_byte = 1'($urandom);
			pending_bytes.push_back(it);
		end
	endtask

	task automatic random_traffic(input int min_bytes, input int min_packets);
		int        b0;
		int        n0;
		int        r;
		int        opt;
		pkt_kind_t kind;
		bit        closed;
		b0 = stim_bytes;
		n0 = stim_packets;
		while (stim_bytes - b0 < min_bytes || stim_packets - n0 < min_packets) begin
			r = $urandom_range(0, 99);
			kind = (r < 45) ? PKT_V4 : (r < 85) ? PKT_V6 : PKT_OTHER;
			case (kind)
			PKT_V4: begin
				r = $urandom_range(0, 7);
				opt = (r == 0) ? $urandom_range(0, 4) : (r == 1) ? $urandom_range(6, 15) : 5;
			end
			PKT_V6: begin
				r = $urandom_range(0, 9);
				if (r < 4)
					opt = 0;
				else if (r < 8)
					opt = $urandom_range(1, 3);
				else if (r == 8)
					opt = MAX_EXT_HEADERS;
				else
					opt = MAX_EXT_HEADERS + $urandom_range(1, 2);
			end
			default: opt = $urandom_range(0, 65535);
			endcase
			closed = $urandom_range(0, 15) != 0;
			gen_packet(kind, opt, pick_proto(),
				($urandom_range(0, 7) == 0) ? $urandom_range(1, 44) : 0, closed);
			if (closed && $urandom_range(0, 9) == 0)
				add_stray_bytes($urandom_range(1, 3));
		end
		// Leave the parser idle before the next register change.
		gen_packet(PKT_OTHER, $urandom_range(0, 65535), 8'd0, 0, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Register writes and phase control
	// ------------------------------------------------------------------
	task automatic cfg_write(input reg_index_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
		REG_WILDCARD_MASK:     filter_setting.wildcard_mask = val[7:0];
		REG_IPV4_ADDRESS_PAIR: filter_setting.ipv4_address_pair = val;
		REG_PROTOCOL_PAIR:     filter_setting.protocol_pair = val[23:0];
		REG_PORT_PAIR:         filter_setting.port_pair = val[31:0];
		REG_IPV6_SOURCE_UPPER: filter_setting.ipv6_source_upper = val;
		REG_IPV6_SOURCE_LOWER: filter_setting.ipv6_source_lower = val;
		REG_IPV6_DEST_UPPER:   filter_setting.ipv6_dest_upper = val;
		REG_IPV6_DEST_LOWER:   filter_setting.ipv6_dest_lower = val;
		default: begin
		end
		endcase
	endtask

	task automatic load_filter(input filter_cfg_t c);
		cfg_write(REG_WILDCARD_MASK, 64'(c.wildcard_mask));
		cfg_write(REG_IPV4_ADDRESS_PAIR, c.ipv4_address_pair);
		cfg_write(REG_PROTOCOL_PAIR, 64'(c.protocol_pair));
		cfg_write(REG_PORT_PAIR, 64'(c.port_pair));
		cfg_write(REG_IPV6_SOURCE_UPPER, c.ipv6_source_upper);
		cfg_write(REG_IPV6_SOURCE_LOWER, c.ipv6_source_lower);
		cfg_write(REG_IPV6_DEST_UPPER, c.ipv6_dest_upper);
		cfg_write(REG_IPV6_DEST_LOWER, c.ipv6_dest_lower);
	endtask

	function automatic filter_cfg_t random_filter();
		filter_cfg_t c;
		c.wildcard_mask = 8'($urandom);
		c.ipv4_address_pair = {$urandom, $urandom};
		c.protocol_pair[23:8] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: ($urandom_range(0, 1) ? ETH_IPV4 : ETH_IPV6);
		c.protocol_pair[7:0] = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
		c.port_pair = $urandom;
		c.ipv6_source_upper = {$urandom, $urandom};
		c.ipv6_source_lower = {$urandom, $urandom};
		c.ipv6_dest_upper = {$urandom, $urandom};
		c.ipv6_dest_lower = {$urandom, $urandom};
		return c;
	endfunction

	// Wait until every byte is taken and every verdict is back, then let the
	// pipeline settle so a trailing byte without a verdict is finished too.
	task automatic drain();
		while (pending_bytes.size() != 0 || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Byte driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			send_gap <= 0;
		end else if (!(byte_valid && byte_stall)) begin
			if (byte_valid) begin
				predict_verdict(byte_item);
				void'(pending_bytes.pop_front());
				bytes_taken++;
			end
			if (send_gap > 0) begin
				byte_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				byte_valid <= 1'b0;
				send_gap <= $urandom_range(0, 2);
			end else if (pending_bytes.size() != 0) begin
				byte_valid <= 1'b1;
				byte_item <= pending_bytes[0];
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: stall pattern, including one long hold-off
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && !calm && verdicts_seen >= 10) begin
			result_stall <= 1'b1;
			hold_left <= LONG_HOLD - 1;
			hold_done <= 1'b1;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : verdict_monitor
		result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			verdicts_seen++;
			if (result_item.matched)
				matches_seen++;
			if (expected_verdicts.size() == 0) begin
				report_error("verdict arrived with no packet closed");
			end else begin
				want = expected_verdicts.pop_front();
				check_field("matched", 64'(result_item.matched), 64'(want.matched));
				check_field("net_protocol", 64'(result_item.net_protocol),
					64'(want.net_protocol));
				check_field("transport_protocol", 64'(result_item.transport_protocol),
					64'(want.transport_protocol));
				check_field("ipv4_source", 64'(result_item.ipv4_source), 64'(want.ipv4_source));
				check_field("ipv4_dest", 64'(result_item.ipv4_dest), 64'(want.ipv4_dest));
				check_field("source_port", 64'(result_item.source_port), 64'(want.source_port));
				check_field("dest_port", 64'(result_item.dest_port), 64'(want.dest_port));
			end
		end
	end

	// Ends a run that has stopped moving.
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : sequence_main
		filter_cfg_t c;
		filter_setting = '0;
		filter_setting.wildcard_mask = 8'hFF;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: everything is wildcarded, so verdicts follow the parse.
		gen_packet(PKT_V4, 5, PROTO_TCP, 0, 1'b1);
		gen_packet(PKT_V4, 15, PROTO_UDP, 0, 1'b1);
		gen_packet(PKT_V4, 2, 8'd1, 0, 1'b1);
		gen_packet(PKT_V6, 0, PROTO_TCP, 0, 1'b1);
		gen_packet(PKT_V6, 3, PROTO_UDP, 0, 1'b1);
		gen_packet(PKT_V6, MAX_EXT_HEADERS + 1, PROTO_TCP, 0, 1'b1);
		gen_packet(PKT_OTHER, 16'hFFFF, 8'd0, 1, 1'b1);
		gen_packet(PKT_OTHER, 16'h0000, 8'd0, 0, 1'b1);
		gen_packet(PKT_V4, 5, PROTO_TCP, 10, 1'b1);
		gen_packet(PKT_V6, 0, PROTO_UDP, 20, 1'b0);
		gen_packet(PKT_V4, 5, PROTO_UDP, 0, 1'b1);
		add_stray_bytes(3);
		gen_packet(PKT_V4, 5, PROTO_TCP, 1, 1'b1);
		gen_packet(PKT_V4, 5, PROTO_UDP, 22, 1'b1);
		drain();

		// Nothing wildcarded; an exact IPv4/TCP match, then an L4 and an L3 miss.
		c = random_filter();
		c.wildcard_mask = 8'h00;
		c.protocol_pair = {ETH_IPV4, PROTO_TCP};
		load_filter(c);
		aim_exact = 1'b1;
		gen_packet(PKT_V4, 5, PROTO_TCP, 0, 1'b1);
		gen_packet(PKT_V4, 5, PROTO_UDP, 0, 1'b1);
		gen_packet(PKT_V6, 0, PROTO_TCP, 0, 1'b1);
		aim_exact = 1'b0;
		random_traffic(1, 1);
		drain();

		c = '1;
		load_filter(c);
		random_traffic(1, 1);
		drain();

		c = '0;
		load_filter(c);
		random_traffic(1, 1);
		drain();

		load_filter(random_filter());
		random_traffic(1, 1);
		drain();

		calm = 1'b1;
		load_filter(random_filter());
		random_traffic(1, 1);
		drain();

		if (expected_verdicts.size() != 0)
			report_error($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
		$display("covered %0d packet bytes in %0d packets under 6 filter settings (%0d writes)",
			bytes_taken, stim_packets, cfg_writes);
		$display("checked %0d verdicts, %0d of them matches; %0d errors",
			verdicts_seen, matches_seen, error_count);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
